### sv/cspl_pkg.sv
// cspl_pkg: shared types, widths and codes for the cubic spline segment evaluator
// no dependencies; imported by cspl_weights, cubic_spline_segment_eval, cspl_checker and the testbench
`timescale 1ns / 1ps

package cspl_pkg;

   localparam int COORD_W = 32;
   localparam int TIME_W  = 16;
   localparam int Q14_W   = 16;
   localparam int CSR_W   = 16;
   localparam int IDX_W   = 2;
   localparam int NPTS    = 4;

   // exact basis polynomials carry 48 fractional bits
   localparam int POLY_W  = 54;
   // weights carry 28 fractional bits
   localparam int WGT_W   = 32;
   localparam int PROD_W  = 64;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_BASIS_MODE = 2'd0;
   localparam logic [IDX_W-1:0] CSR_TENSION    = 2'd1;
   localparam logic [IDX_W-1:0] CSR_BIAS       = 2'd2;

   typedef enum logic [1:0] {
      BASIS_LINEAR  = 2'd0,
      BASIS_CATMULL = 2'd1,
      BASIS_CUBIC   = 2'd2,
      BASIS_HERMITE = 2'd3
   } basis_type;

   typedef logic [NPTS-1:0][COORD_W-1:0] pts_type;

   typedef struct packed {
      basis_type               mode;
      logic signed [Q14_W-1:0] tension;
      logic signed [Q14_W-1:0] bias;
   } cfg_type;

   // control points with their rounded Q28 weights
   typedef struct packed {
      pts_type                      pt;
      logic [NPTS-1:0][WGT_W-1:0]   wt;
   } wgt_type;

endpackage

### sv/cubic_spline_segment_eval.sv
// cubic_spline_segment_eval: one axis of a cubic spline segment, fixed point
// throughput: one word per cycle through 8 register stages (t powers, basis, weights,
// products, two-level sum); a stall freezes only stages that hold a word
// reset: clears all valid bits; basis_mode returns to catmull-rom, tension and bias to 0
`timescale 1ns / 1ps

module cubic_spline_segment_eval (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [cspl_pkg::COORD_W-1:0]  req_ctrl_before,
   input  logic signed [cspl_pkg::COORD_W-1:0]  req_seg_start,
   input  logic signed [cspl_pkg::COORD_W-1:0]  req_seg_end,
   input  logic signed [cspl_pkg::COORD_W-1:0]  req_ctrl_after,
   input  logic        [cspl_pkg::TIME_W-1:0]   req_local_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [cspl_pkg::COORD_W-1:0]  rsp_coord_out,
   output logic                                 rsp_saturated,
   input  logic                                 csr_wen,
   input  logic        [cspl_pkg::IDX_W-1:0]    csr_index,
   input  logic        [cspl_pkg::CSR_W-1:0]    csr_wdata
);
   import cspl_pkg::*;

   localparam int SUM_W = PROD_W + 1;
   localparam int ACC_W = PROD_W + 2;
   localparam int RES_W = ACC_W - 28;
   localparam logic signed [ACC_W-1:0]   HALF28 = ACC_W'(1) <<< 27;
   localparam logic signed [RES_W-1:0]   R_MAX  = RES_W'(32'h7FFF_FFFF);
   localparam logic signed [RES_W-1:0]   R_MIN  = ~R_MAX;
   localparam logic signed [COORD_W-1:0] C_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] C_MIN  = 32'sh8000_0000;

   basis_type               mode_ff;
   logic signed [Q14_W-1:0] tension_ff, bias_ff;
   cfg_type                 cfg;

   pts_type  req_pts;
   logic     w_valid, w_ready;
   wgt_type  w_word;

   logic en_f, en_g, en_h;
   logic f_v_ff, g_v_ff, rsp_valid_ff;

   logic signed [PROD_W-1:0]  f_prod_ff [NPTS];
   logic signed [SUM_W-1:0]   g_s01_ff, g_s23_ff;
   logic signed [ACC_W-1:0]   h_acc;
   logic signed [RES_W-1:0]   h_r;
   logic signed [COORD_W-1:0] coord_in, rsp_coord_ff;
   logic                      sat_in, rsp_sat_ff;

   // ---------------- configuration registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= BASIS_CATMULL;
         tension_ff <= '0;
         bias_ff    <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_BASIS_MODE: mode_ff    <= basis_type'(csr_wdata[1:0]);
            CSR_TENSION:    tension_ff <= csr_wdata;
            CSR_BIAS:       bias_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.mode    = mode_ff;
   assign cfg.tension = tension_ff;
   assign cfg.bias    = bias_ff;

   assign req_pts = {req_ctrl_after, req_seg_end, req_seg_start, req_ctrl_before};

   cspl_weights u_weights (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_pts    (req_pts),
      .in_time   (req_local_time),
      .out_valid (w_valid),
      .out_ready (w_ready),
      .out_word  (w_word)
   );

   // ---------------- stage enables ----------------
   assign en_h    = !rsp_valid_ff || rsp_ready;
   assign en_g    = !g_v_ff || en_h;
   assign en_f    = !f_v_ff || en_g;
   assign w_ready = en_f;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff       <= 1'b0;
         g_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_f) f_v_ff       <= w_valid;
         if (en_g) g_v_ff       <= f_v_ff;
         if (en_h) rsp_valid_ff <= g_v_ff;
      end
   end

   // ---------------- stage f: point times weight ----------------
   always_ff @(posedge clock) begin
      if (en_f) begin
         for (int i = 0; i < NPTS; i++) begin
            f_prod_ff[i] <= $signed(w_word.pt[i]) * $signed(w_word.wt[i]);
         end
      end
   end

   // ---------------- stage g: pair sums ----------------
   always_ff @(posedge clock) begin
      if (en_g) begin
         g_s01_ff <= SUM_W'(f_prod_ff[0]) + SUM_W'(f_prod_ff[1]);
         g_s23_ff <= SUM_W'(f_prod_ff[2]) + SUM_W'(f_prod_ff[3]);
      end
   end

   // ---------------- stage h: round to q16, saturate ----------------
   always_comb begin
      h_acc    = ACC_W'(g_s01_ff) + ACC_W'(g_s23_ff) + HALF28;
      h_r      = h_acc[ACC_W-1:28];
      coord_in = h_r[COORD_W-1:0];
      sat_in   = 1'b0;
      if (h_r > R_MAX) begin
         coord_in = C_MAX;
         sat_in   = 1'b1;
      end else if (h_r < R_MIN) begin
         coord_in = C_MIN;
         sat_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en_h) begin
         rsp_coord_ff <= coord_in;
         rsp_sat_ff   <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_coord_out = rsp_coord_ff;
   assign rsp_saturated = rsp_sat_ff;

`ifndef SYNTHESIS
   sat_bound_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sat_ff |-> rsp_coord_ff == C_MAX || rsp_coord_ff == C_MIN)
      else $error("saturation flag without a clipped word");

   stage_g_hold_a: assert property (@(posedge clock) disable iff (reset)
      g_v_ff && !en_g |=> g_v_ff && $stable(g_s01_ff) && $stable(g_s23_ff))
      else $error("stalled sum stage lost or changed its word");

   stage_f_move_a: assert property (@(posedge clock) disable iff (reset)
      f_v_ff && en_g |=> g_v_ff)
      else $error("product word dropped on its way to the sum stage");
`endif

endmodule

### sv/cspl_weights.sv
// cspl_weights: five-stage pipeline from local time to the four Q28 point weights
// depends on cspl_pkg; instantiated by cubic_spline_segment_eval
`timescale 1ns / 1ps

module cspl_weights (
   input  logic                          clock,
   input  logic                          reset,
   input  cspl_pkg::cfg_type             cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  cspl_pkg::pts_type             in_pts,
   input  logic [cspl_pkg::TIME_W-1:0]   in_time,
   output logic                          out_valid,
   input  logic                          out_ready,
   output cspl_pkg::wgt_type             out_word
);
   import cspl_pkg::*;

   localparam logic signed [Q14_W-1:0]  Q14_ONE  = 16'sd16384;
   localparam logic [30:0]              PA_MAX   = 31'd1 << 30;
   localparam logic signed [POLY_W-1:0] ONE_Q48  = POLY_W'(1) <<< 48;
   localparam logic signed [POLY_W-1:0] HALF20   = POLY_W'(1) <<< 19;
   localparam logic signed [POLY_W-1:0] HALF21   = POLY_W'(1) <<< 20;
   localparam logic signed [PROD_W-1:0] HALF29   = PROD_W'(1) <<< 28;

   // tangent factors, refreshed every cycle from the registers
   logic signed [Q14_W-1:0] ten_c, bia_c;
   logic signed [Q14_W:0]   omt_in, opa_in, omb_in;
   logic [Q14_W-1:0]        omt_ff, opa_ff, omb_ff;
   logic [31:0]             pa_full, pb_full;
   logic [30:0]             pa_ff, pb_ff;
   logic signed [31:0]      dpp_ff;

   logic en_a, en_b, en_c, en_d, en_e;
   logic a_v_ff, b_v_ff, c_v_ff, d_v_ff, e_v_ff;

   pts_type             a_pts_ff, b_pts_ff, c_pts_ff, d_pts_ff, e_pts_ff;
   logic [TIME_W-1:0]   a_t_ff, b_t_ff;
   logic [31:0]         a_tsq_ff, b_tsq_ff;
   logic [47:0]         b_tcu_ff;

   logic signed [POLY_W-1:0] t1_s, t2_s, t3_s;
   logic signed [POLY_W-1:0] q_in [NPTS];
   logic signed [POLY_W-1:0] c_q_ff [NPTS];

   logic                     c_cat;
   logic signed [WGT_W-1:0]  c_b [NPTS];
   logic signed [WGT_W-1:0]  d_b_ff [NPTS];
   logic signed [31:0]       pa_s, pb_s;
   logic signed [PROD_W-1:0] d_h10pa_ff, d_h10d_ff, d_h01pa_ff;
   logic signed [PROD_W-1:0] d_h10pb_ff, d_h01d_ff, d_h01pb_ff;

   logic signed [PROD_W-1:0] x0_in, x1_in, x2_in, x3_in;
   logic signed [WGT_W-1:0]  w_in [NPTS];
   logic signed [WGT_W-1:0]  e_w_ff [NPTS];

   // ---------------- tangent factors ----------------
   always_comb begin
      ten_c = cfg.tension;
      if (cfg.tension > Q14_ONE) ten_c = Q14_ONE;
      else if (cfg.tension < -Q14_ONE) ten_c = -Q14_ONE;
      bia_c = cfg.bias;
      if (cfg.bias > Q14_ONE) bia_c = Q14_ONE;
      else if (cfg.bias < -Q14_ONE) bia_c = -Q14_ONE;
      omt_in = 17'(Q14_ONE) - 17'(ten_c);
      opa_in = 17'(Q14_ONE) + 17'(bia_c);
      omb_in = 17'(Q14_ONE) - 17'(bia_c);
   end

   assign pa_full = opa_ff * omt_ff;
   assign pb_full = omb_ff * omt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         omt_ff <= Q14_W'(Q14_ONE);
         opa_ff <= Q14_W'(Q14_ONE);
         omb_ff <= Q14_W'(Q14_ONE);
         pa_ff  <= 31'd1 << 28;
         pb_ff  <= 31'd1 << 28;
         dpp_ff <= '0;
      end else begin
         omt_ff <= omt_in[Q14_W-1:0];
         opa_ff <= opa_in[Q14_W-1:0];
         omb_ff <= omb_in[Q14_W-1:0];
         pa_ff  <= pa_full[30:0];
         pb_ff  <= pb_full[30:0];
         dpp_ff <= $signed({1'b0, pa_ff}) - $signed({1'b0, pb_ff});
      end
   end

   // ---------------- stage enables ----------------
   assign en_e     = !e_v_ff || out_ready;
   assign en_d     = !d_v_ff || en_e;
   assign en_c     = !c_v_ff || en_d;
   assign en_b     = !b_v_ff || en_c;
   assign en_a     = !a_v_ff || en_b;
   assign in_ready = en_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
      end else begin
         if (en_a) a_v_ff <= in_valid;
         if (en_b) b_v_ff <= a_v_ff;
         if (en_c) c_v_ff <= b_v_ff;
         if (en_d) d_v_ff <= c_v_ff;
         if (en_e) e_v_ff <= d_v_ff;
      end
   end

   // ---------------- stage a: t squared ----------------
   always_ff @(posedge clock) begin
      if (en_a) begin
         a_pts_ff <= in_pts;
         a_t_ff   <= in_time;
         a_tsq_ff <= in_time * in_time;
      end
   end

   // ---------------- stage b: t cubed ----------------
   always_ff @(posedge clock) begin
      if (en_b) begin
         b_pts_ff <= a_pts_ff;
         b_t_ff   <= a_t_ff;
         b_tsq_ff <= a_tsq_ff;
         b_tcu_ff <= 48'(a_tsq_ff) * 48'(a_t_ff);
      end
   end

   // ---------------- stage c: exact basis polynomials plus rounding half ----------------
   assign t1_s = POLY_W'({b_t_ff, 32'd0});
   assign t2_s = POLY_W'({b_tsq_ff, 16'd0});
   assign t3_s = POLY_W'(b_tcu_ff);

   always_comb begin
      for (int i = 0; i < NPTS; i++) q_in[i] = '0;
      case (cfg.mode)
         BASIS_LINEAR: begin
            q_in[1] = ONE_Q48 - t1_s + HALF20;
            q_in[2] = t1_s + HALF20;
         end
         BASIS_CATMULL: begin
            q_in[0] = -t3_s + (t2_s <<< 1) - t1_s + HALF21;
            q_in[1] = t3_s + (t3_s <<< 1) - (t2_s <<< 2) - t2_s + (ONE_Q48 <<< 1) + HALF21;
            q_in[2] = -t3_s - (t3_s <<< 1) + (t2_s <<< 2) + t1_s + HALF21;
            q_in[3] = t3_s - t2_s + HALF21;
         end
         BASIS_CUBIC: begin
            q_in[0] = -t3_s + (t2_s <<< 1) - t1_s + HALF20;
            q_in[1] = t3_s - (t2_s <<< 1) + ONE_Q48 + HALF20;
            q_in[2] = -t3_s + t2_s + t1_s + HALF20;
            q_in[3] = t3_s - t2_s + HALF20;
         end
         BASIS_HERMITE: begin
            // h00, h10, h01, h11 in that order
            q_in[0] = (t3_s <<< 1) - t2_s - (t2_s <<< 1) + ONE_Q48 + HALF20;
            q_in[1] = t3_s - (t2_s <<< 1) + t1_s + HALF20;
            q_in[2] = t3_s - t2_s + HALF20;
            q_in[3] = -(t3_s <<< 1) + t2_s + (t2_s <<< 1) + HALF20;
         end
         default: begin
            for (int i = 0; i < NPTS; i++) q_in[i] = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_pts_ff <= b_pts_ff;
         for (int i = 0; i < NPTS; i++) c_q_ff[i] <= q_in[i];
      end
   end

   // ---------------- stage d: drop to q28, hermite tangent products ----------------
   assign c_cat = (cfg.mode == BASIS_CATMULL);

   always_comb begin
      for (int i = 0; i < NPTS; i++) begin
         c_b[i] = c_cat ? c_q_ff[i][52:21] : c_q_ff[i][51:20];
      end
   end

   assign pa_s = $signed({1'b0, pa_ff});
   assign pb_s = $signed({1'b0, pb_ff});

   always_ff @(posedge clock) begin
      if (en_d) begin
         d_pts_ff   <= c_pts_ff;
         for (int i = 0; i < NPTS; i++) d_b_ff[i] <= c_b[i];
         d_h10pa_ff <= c_b[1] * pa_s;
         d_h10d_ff  <= c_b[1] * dpp_ff;
         d_h01pa_ff <= c_b[2] * pa_s;
         d_h10pb_ff <= c_b[1] * pb_s;
         d_h01d_ff  <= c_b[2] * dpp_ff;
         d_h01pb_ff <= c_b[2] * pb_s;
      end
   end

   // ---------------- stage e: point weights ----------------
   always_comb begin
      x0_in = HALF29 - d_h10pa_ff;
      x1_in = (PROD_W'(d_b_ff[0]) <<< 29) + d_h10d_ff - d_h01pa_ff + HALF29;
      x2_in = (PROD_W'(d_b_ff[3]) <<< 29) + d_h10pb_ff + d_h01d_ff + HALF29;
      x3_in = d_h01pb_ff + HALF29;
      if (cfg.mode == BASIS_HERMITE) begin
         w_in[0] = x0_in[60:29];
         w_in[1] = x1_in[60:29];
         w_in[2] = x2_in[60:29];
         w_in[3] = x3_in[60:29];
      end else begin
         for (int i = 0; i < NPTS; i++) w_in[i] = d_b_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en_e) begin
         e_pts_ff <= d_pts_ff;
         for (int i = 0; i < NPTS; i++) e_w_ff[i] <= w_in[i];
      end
   end

   assign out_valid = e_v_ff;

   always_comb begin
      out_word.pt = e_pts_ff;
      for (int i = 0; i < NPTS; i++) out_word.wt[i] = e_w_ff[i];
   end

`ifndef SYNTHESIS
   tangent_range_a: assert property (@(posedge clock) disable iff (reset)
      pa_ff <= PA_MAX && pb_ff <= PA_MAX)
      else $error("tangent factor above four");

   stage_a_hold_a: assert property (@(posedge clock) disable iff (reset)
      a_v_ff && !en_b |=> a_v_ff && $stable(a_tsq_ff) && $stable(a_t_ff))
      else $error("stalled stage a lost or changed its word");

   full_only_a: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> a_v_ff && b_v_ff && c_v_ff && d_v_ff && e_v_ff)
      else $error("input stalled with a bubble in the pipeline");
`endif

endmodule

### dv/cspl_checker.sv
// cspl_checker: watches the request, response and csr ports of cubic_spline_segment_eval,
// predicts each response word in exact fixed point and compares it field by field
// depends on cspl_pkg for widths, register indexes and the basis enum
`timescale 1ns / 1ps

module cspl_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic signed [cspl_pkg::COORD_W-1:0]  req_ctrl_before,
   input  logic signed [cspl_pkg::COORD_W-1:0]  req_seg_start,
   input  logic signed [cspl_pkg::COORD_W-1:0]  req_seg_end,
   input  logic signed [cspl_pkg::COORD_W-1:0]  req_ctrl_after,
   input  logic        [cspl_pkg::TIME_W-1:0]   req_local_time,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [cspl_pkg::COORD_W-1:0]  rsp_coord_out,
   input  logic                                 rsp_saturated,
   input  logic                                 csr_wen,
   input  logic        [cspl_pkg::IDX_W-1:0]    csr_index,
   input  logic        [cspl_pkg::CSR_W-1:0]    csr_wdata,
   output int                                   mismatches,
   output int                                   outstanding
);
   import cspl_pkg::*;

   localparam int REPORT_LIMIT = 10;
   localparam int Q14_ONE      = 16384;

   // wide enough that no intermediate product or sum can wrap
   typedef logic signed [127:0] exact_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] coord;
      logic                      clipped;
   } point_type;

   localparam exact_type COORD_MAX = (exact_type'(1) <<< (COORD_W - 1)) - 1;
   localparam exact_type COORD_MIN = -(exact_type'(1) <<< (COORD_W - 1));

   basis_type               mode_q;
   logic signed [Q14_W-1:0] tension_q;
   logic signed [Q14_W-1:0] bias_q;
   point_type               pending_points[$];
   point_type               got;
   point_type               want;
   int                      errors;

   function automatic exact_type round_half_up(input exact_type x, input int s);
      return (x + (exact_type'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic exact_type clamp_unit(input exact_type v);
      if (v > Q14_ONE) return Q14_ONE;
      if (v < -Q14_ONE) return -Q14_ONE;
      return v;
   endfunction

   function automatic point_type eval_segment(
      input logic signed [COORD_W-1:0] p0,
      input logic signed [COORD_W-1:0] p1,
      input logic signed [COORD_W-1:0] p2,
      input logic signed [COORD_W-1:0] p3,
      input logic        [TIME_W-1:0]  lt,
      input basis_type                 m,
      input logic signed [Q14_W-1:0]   ten_raw,
      input logic signed [Q14_W-1:0]   bias_raw
   );
      exact_type pt[NPTS];
      exact_type wt[NPTS];
      exact_type t, t1, t2, t3, one_q48, unit;
      exact_type h00, h10, h01, h11, ten, bia, pa, pb, d, acc, r;
      point_type res;
      int        i;

      pt[0] = p0;
      pt[1] = p1;
      pt[2] = p2;
      pt[3] = p3;
      t = {112'd0, lt};
      t1 = t <<< 32;
      t2 = (t * t) <<< 16;
      t3 = t * t * t;
      one_q48 = exact_type'(1) <<< 48;

      case (m)
         BASIS_LINEAR: begin
            wt[0] = 0;
            wt[1] = round_half_up(one_q48 - t1, 20);
            wt[2] = round_half_up(t1, 20);
            wt[3] = 0;
         end
         BASIS_CATMULL: begin
            // the one-half factor is folded into the extra shift
            wt[0] = round_half_up(-t3 + 2 * t2 - t1, 21);
            wt[1] = round_half_up(3 * t3 - 5 * t2 + 2 * one_q48, 21);
            wt[2] = round_half_up(-3 * t3 + 4 * t2 + t1, 21);
            wt[3] = round_half_up(t3 - t2, 21);
         end
         BASIS_CUBIC: begin
            wt[0] = round_half_up(-t3 + 2 * t2 - t1, 20);
            wt[1] = round_half_up(t3 - 2 * t2 + one_q48, 20);
            wt[2] = round_half_up(-t3 + t2 + t1, 20);
            wt[3] = round_half_up(t3 - t2, 20);
         end
         default: begin
            h00 = round_half_up(2 * t3 - 3 * t2 + one_q48, 20);
            h10 = round_half_up(t3 - 2 * t2 + t1, 20);
            h01 = round_half_up(t3 - t2, 20);
            h11 = round_half_up(-2 * t3 + 3 * t2, 20);
            ten = clamp_unit(ten_raw);
            bia = clamp_unit(bias_raw);
            // q2.28 tangent factors, halved through the 29-bit shift
            pa = (Q14_ONE + bia) * (Q14_ONE - ten);
            pb = (Q14_ONE - bia) * (Q14_ONE - ten);
            d = pa - pb;
            unit = exact_type'(1) <<< 29;
            wt[0] = round_half_up(-h10 * pa, 29);
            wt[1] = round_half_up(h00 * unit + h10 * d - h01 * pa, 29);
            wt[2] = round_half_up(h11 * unit + h10 * pb + h01 * d, 29);
            wt[3] = round_half_up(h01 * pb, 29);
         end
      endcase

      acc = 0;
      for (i = 0; i < NPTS; i++) acc += pt[i] * wt[i];
      r = round_half_up(acc, 28);
      res.clipped = 1'b0;
      if (r > COORD_MAX) begin
         r = COORD_MAX;
         res.clipped = 1'b1;
      end else if (r < COORD_MIN) begin
         r = COORD_MIN;
         res.clipped = 1'b1;
      end
      res.coord = r[COORD_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         mode_q = BASIS_CATMULL;
         tension_q = '0;
         bias_q = '0;
         pending_points.delete();
         errors = 0;
      end else begin
         // predict with the settings in force before any write at this edge
         if (req_valid && req_ready) begin
            pending_points.insert(pending_points.size(),
               eval_segment(req_ctrl_before, req_seg_start, req_seg_end,
                  req_ctrl_after, req_local_time, mode_q, tension_q, bias_q));
         end
         if (rsp_valid && rsp_ready) begin
            got.coord = rsp_coord_out;
            got.clipped = rsp_saturated;
            if (pending_points.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("unexpected response word: coord_out %h saturated %b",
                     got.coord, got.clipped);
            end else begin
               want = pending_points.pop_front();
               if (got.coord !== want.coord || got.clipped !== want.clipped) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display({"mismatch: coord_out expected %h got %h, ",
                               "saturated expected %b got %b"},
                        want.coord, got.coord, want.clipped, got.clipped);
               end
            end
         end
         if (csr_wen) begin
            case (csr_index)
               CSR_BASIS_MODE: mode_q = basis_type'(csr_wdata[1:0]);
               CSR_TENSION:    tension_q = csr_wdata;
               CSR_BIAS:       bias_q = csr_wdata;
               default: ;
            endcase
         end
      end
      mismatches <= errors;
      outstanding <= pending_points.size();
   end

endmodule

### dv/tb_cubic_spline_segment_eval.sv
// tb_cubic_spline_segment_eval: drives segment words and register settings into
// cubic_spline_segment_eval with random idling and a long response hold-off
// depends on cspl_pkg, cubic_spline_segment_eval and cspl_checker
`timescale 1ns / 1ps

module tb_cubic_spline_segment_eval;
   import cspl_pkg::*;

   localparam int WORDS_PER_PHASE = 102;
   localparam int RANDOM_PHASES   = 14;
   localparam int SETTLE_CYCLES   = 10;
   localparam int DRAIN_CYCLES    = 20;
   localparam int HOLD_CYCLES     = 300;
   localparam int QUIET_LIMIT     = 5000;

   localparam logic [IDX_W-1:0]   CSR_UNUSED = 2'd3;
   localparam logic [COORD_W-1:0] CMAX = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] CMIN = 32'h8000_0000;

   typedef struct packed {
      logic [COORD_W-1:0] ctrl_before;
      logic [COORD_W-1:0] seg_start;
      logic [COORD_W-1:0] seg_end;
      logic [COORD_W-1:0] ctrl_after;
      logic [TIME_W-1:0]  local_time;
   } segment_word_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [COORD_W-1:0]  req_ctrl_before = '0;
   logic signed [COORD_W-1:0]  req_seg_start = '0;
   logic signed [COORD_W-1:0]  req_seg_end = '0;
   logic signed [COORD_W-1:0]  req_ctrl_after = '0;
   logic        [TIME_W-1:0]   req_local_time = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [COORD_W-1:0]  rsp_coord_out;
   logic                       rsp_saturated;
   logic                       csr_wen = 1'b0;
   logic        [IDX_W-1:0]    csr_index = '0;
   logic        [CSR_W-1:0]    csr_wdata = '0;

   int mismatches;
   int outstanding;
   int tx_style = 1;
   int rx_style = 1;
   int hold_requests = 0;
   int quiet_cycles = 0;

   cubic_spline_segment_eval DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ctrl_before (req_ctrl_before),
      .req_seg_start   (req_seg_start),
      .req_seg_end     (req_seg_end),
      .req_ctrl_after  (req_ctrl_after),
      .req_local_time  (req_local_time),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_coord_out   (rsp_coord_out),
      .rsp_saturated   (rsp_saturated),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   cspl_checker spline_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ctrl_before (req_ctrl_before),
      .req_seg_start   (req_seg_start),
      .req_seg_end     (req_seg_end),
      .req_ctrl_after  (req_ctrl_after),
      .req_local_time  (req_local_time),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_coord_out   (rsp_coord_out),
      .rsp_saturated   (rsp_saturated),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // style 0 never idles, 1 idles freely, 2 idles now and then
   function automatic int draw_wait(input int style);
      case (style)
         0:       return 0;
         1:       return $urandom_range(0, 18);
         default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord();
      int unsigned k;
      k = $urandom_range(0, 9);
      if (k == 0) begin
         case ($urandom_range(0, 3))
            0:       return CMAX;
            1:       return CMIN;
            2:       return '0;
            default: return '1;
         endcase
      end
      if (k < 4) return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      if (k < 6) return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
      return $urandom;
   endfunction

   function automatic logic [TIME_W-1:0] pick_time();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return '1;
         2:       return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // mostly in range, sometimes any pattern so the clamp is exercised
   function automatic logic [CSR_W-1:0] pick_q14();
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 32768) - 16384);
   endfunction

   task automatic send_word(input segment_word_type w);
      int gap;
      gap = draw_wait(tx_style);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ctrl_before <= w.ctrl_before;
      req_seg_start <= w.seg_start;
      req_seg_end <= w.seg_end;
      req_ctrl_after <= w.ctrl_after;
      req_local_time <= w.local_time;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_idle();
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input basis_type m, input logic [CSR_W-1:0] ten,
                               input logic [CSR_W-1:0] bi);
      wait_idle();
      // upper bits of the mode word are junk, the block keeps only two
      csr_wen <= 1'b1;
      csr_index <= CSR_BASIS_MODE;
      csr_wdata <= {14'($urandom), m};
      @(posedge clock);
      csr_index <= CSR_TENSION;
      csr_wdata <= ten;
      @(posedge clock);
      csr_index <= CSR_BIAS;
      csr_wdata <= bi;
      @(posedge clock);
      csr_index <= CSR_UNUSED;
      csr_wdata <= 16'($urandom);
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // response side: one stall draw per word, plus the long hold-off on request
   initial begin
      int stall;
      int holds_done;
      holds_done = 0;
      wait (!reset);
      forever begin
         stall = draw_wait(rx_style);
         if (holds_done < hold_requests) begin
            holds_done++;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      segment_word_type word;
      int               phase;
      int               n;
      int               m;
      basis_type        mode;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: catmull-rom
      send_word('{32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h0004_0000, 16'h4000});
      req_valid <= 1'b0;

      for (m = 0; m < 4; m++) begin
         // hermite here gets tension and bias beyond range, clamped to -1 and +1
         program_regs(basis_type'(m), 16'h8000, 16'h7FFF);
         send_word('{CMAX, CMAX, CMAX, CMAX, 16'hFFFF});
         send_word('{CMIN, CMIN, CMIN, CMIN, 16'h0000});
         // overshoot both ways, saturates under the cubic bases
         send_word('{CMIN, CMAX, CMAX, CMIN, 16'h8000});
         send_word('{CMAX, CMIN, CMIN, CMAX, 16'h8000});
         // outer points must not matter for linear at t = 0
         send_word('{32'h5A5A_5A5A, 32'h0001_0000, 32'hFFFF_0000, 32'hA5A5_A5A5, 16'h0000});
         req_valid <= 1'b0;
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         tx_style = $urandom_range(0, 2);
         rx_style = $urandom_range(0, 2);
         case (phase)
            0: program_regs(BASIS_HERMITE, 16'hC000, 16'h4000);
            1: program_regs(BASIS_HERMITE, 16'h4000, 16'hC000);
            2: program_regs(BASIS_HERMITE, 16'h0000, 16'h0000);
            3: program_regs(BASIS_HERMITE, 16'h7FFF, 16'h8000);
            default: begin
               mode = (phase < 8) ? basis_type'(phase - 4) : basis_type'($urandom_range(0, 3));
               program_regs(mode, pick_q14(), pick_q14());
            end
         endcase
         if (phase == 5 || phase == 11) begin
            // sender keeps offering while the response side holds off
            tx_style = 0;
            hold_requests++;
         end
         for (n = 0; n < WORDS_PER_PHASE; n++) begin
            // often sweep t over the same control points, as a curve sampler would
            if (n == 0 || $urandom_range(0, 1) == 0) begin
               word.ctrl_before = pick_coord();
               word.seg_start = pick_coord();
               word.seg_end = pick_coord();
               word.ctrl_after = pick_coord();
            end
            word.local_time = pick_time();
            send_word(word);
         end
         req_valid <= 1'b0;
      end

      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
